// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions in the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, ignored while reset is active.
`define WST_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define WST_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/wst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel speed tachometer package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package wst_pkg;

  // Field widths
  localparam int unsigned CIRC_W    = 12;
  localparam int unsigned TIMEOUT_W = 27;
  localparam int unsigned TIME_W    = 40;
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned DIST_W    = 40;
  localparam int unsigned SCNT_W    = 4;

  // Ring of recent speeds
  localparam int unsigned RING_DEPTH = 10;
  localparam int unsigned RING_IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W      = SPEED_W + CNT_W;
  localparam int unsigned COUNT_MAX  = (1 << SCNT_W) - 1;

  // Speed scaling: mm per us to mm per s
  localparam int unsigned SPEED_SCALE = 1000000;
  localparam int unsigned PROD_W      = 32;

  // Serial divider
  localparam int unsigned DIV_NUM_W = 32;
  localparam int unsigned DIV_DEN_W = 40;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = TIMEOUT_W;

  localparam logic [CFG_IDX_W-1:0] REG_CIRCUMFERENCE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STOP_TIMEOUT  = CFG_IDX_W'(1);

  localparam logic [CIRC_W-1:0]    CIRC_RESET    = CIRC_W'(2100);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(10000000);

  // Request commands
  localparam logic CMD_PULSE = 1'b0;
  localparam logic CMD_POLL  = 1'b1;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/core/wst_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel speed tachometer channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface wst_in_if import wst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [TIME_W-1:0] now_us;

  modport source (output valid, output cmd, output now_us, input ready);
  modport sink   (input valid, input cmd, input now_us, output ready);
endinterface

interface wst_out_if import wst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] avg_speed_mm_s;
  logic [DIST_W-1:0]  distance_mm;
  logic               stopped;
  logic [SCNT_W-1:0]  sample_count;

  modport source (output valid, output avg_speed_mm_s, output distance_mm,
                  output stopped, output sample_count, input ready);
  modport sink   (input valid, input avg_speed_mm_s, input distance_mm,
                  input stopped, input sample_count, output ready);
endinterface

// ----- rtl/core/wheel_speed_tachometer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel speed tachometer core
// Pulse-period speed measurement with a moving average over recent speeds.
// ----------------------------------------------------------------------------
// Each request is either a wheel revolution pulse or a poll, stamped with a
// free-running microsecond time; every request yields exactly one result with
// the truncated mean of the nonzero speeds in a ring of the last RING_DEPTH
// revolutions, the distance travelled, a stopped flag and the sample count.
// A pulse computes floor(circumference * 10^6 / period) saturated to 16 bits;
// a poll clears timestamps and ring when the oldest pulse is older than the
// stop timeout. The block handles one request at a time. All division runs
// through one shared restoring divider that yields one quotient bit per cycle,
// and the ring is summed one entry per cycle. When no nonzero speed is stored
// the mean divide is skipped. A finished result sits in an output register,
// so the next request is taken while the previous result still waits; a later
// result holds in the last state until that register is free.
// Configuration must be written only while the block is idle; the block
// itself does not enforce this. Writes to an index beyond the two registers
// are dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wheel_speed_tachometer_core import wst_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  wst_in_if.sink                in_i,
  wst_out_if.source             out_o
);

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b00_0000_0001,
    ST_PULSE     = 10'b00_0000_0010,
    ST_SPD_START = 10'b00_0000_0100,
    ST_SPD_WAIT  = 10'b00_0000_1000,
    ST_AGE       = 10'b00_0001_0000,
    ST_CHECK     = 10'b00_0010_0000,
    ST_SCAN      = 10'b00_0100_0000,
    ST_AVG_START = 10'b00_1000_0000,
    ST_AVG_WAIT  = 10'b01_0000_0000,
    ST_OUT       = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [CIRC_W-1:0]    circ_q;
  logic [TIMEOUT_W-1:0] timeout_q;

  // Measurement state
  logic [TIME_W-1:0]     older_q;
  logic [TIME_W-1:0]     newer_q;
  logic [SPEED_W-1:0]    ring_q [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_vld_q;
  logic [RING_IDX_W-1:0] pos_q;
  logic [DIST_W-1:0]     dist_q;

  // Per-request working registers
  logic [TIME_W-1:0]     now_q;
  logic [TIME_W-1:0]     period_q;
  logic [PROD_W-1:0]     prod_q;
  logic [TIME_W-1:0]     age_q;
  logic [RING_IDX_W-1:0] scan_idx_q;
  logic [SUM_W-1:0]      sum_q;
  logic [CNT_W-1:0]      count_q;
  logic                  stopped_q;
  logic [SPEED_W-1:0]    avg_q;

  // Output register
  logic                  out_vld_q;
  logic [SPEED_W-1:0]    out_avg_q;
  logic [DIST_W-1:0]     out_dist_q;
  logic                  out_stopped_q;
  logic [SCNT_W-1:0]     out_cnt_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                  in_fire;
  logic                  out_free;
  logic                  have_period;
  logic                  timed_out;
  logic                  scan_last;
  logic [SPEED_W-1:0]    scan_entry;
  logic                  scan_take;
  logic [SPEED_W-1:0]    speed_sat;
  logic [31:0]           count_ext;
  logic [SCNT_W-1:0]     count_sat;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;

  assign have_period = (older_q != '0) && (newer_q != '0);
  assign timed_out   = (older_q != '0) && (age_q > TIME_W'(timeout_q));

  assign scan_entry = ring_q[scan_idx_q];
  assign scan_take  = ring_vld_q[scan_idx_q] && (scan_entry != '0);
  assign scan_last  = (scan_idx_q == RING_IDX_W'(RING_DEPTH - 1));

  // Clamp the quotient to the 16-bit speed range; a zero period divides to
  // all ones and lands on the maximum here as well.
  assign speed_sat = (div_rsp.quotient[DIV_NUM_W-1:SPEED_W] != '0) ? '1
                   : div_rsp.quotient[SPEED_W-1:0];

  assign count_ext = 32'(count_q);
  assign count_sat = (count_ext > 32'(COUNT_MAX)) ? SCNT_W'(COUNT_MAX)
                   : count_ext[SCNT_W-1:0];

  // Shared divider: speed divide, then mean divide.
  always_comb begin
    div_req.start    = (state_q == ST_SPD_START) || (state_q == ST_AVG_START);
    div_req.dividend = DIV_NUM_W'(prod_q);
    div_req.divisor  = DIV_DEN_W'(period_q);
    if (state_q == ST_AVG_START) begin
      div_req.dividend = DIV_NUM_W'(sum_q);
      div_req.divisor  = DIV_DEN_W'(count_q);
    end
  end

  wst_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_i.cmd == CMD_PULSE) ? ST_PULSE : ST_AGE;
        end
      end
      ST_PULSE:     state_d = have_period ? ST_SPD_START : ST_SCAN;
      ST_SPD_START: state_d = ST_SPD_WAIT;
      ST_SPD_WAIT: begin
        if (div_rsp.done) begin
          state_d = ST_SCAN;
        end
      end
      ST_AGE:   state_d = ST_CHECK;
      ST_CHECK: state_d = ST_SCAN;
      ST_SCAN: begin
        if (scan_last) begin
          // Nothing to average: skip the divide.
          if ((count_q == '0) && !scan_take) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_AVG_START;
          end
        end
      end
      ST_AVG_START: state_d = ST_AVG_WAIT;
      ST_AVG_WAIT: begin
        if (div_rsp.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and measurement state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      circ_q     <= CIRC_RESET;
      timeout_q  <= TIMEOUT_RESET;
      older_q    <= '0;
      newer_q    <= '0;
      ring_vld_q <= '0;
      pos_q      <= '0;
      dist_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CIRCUMFERENCE: circ_q    <= cfg_wdata_i[CIRC_W-1:0];
          REG_STOP_TIMEOUT:  timeout_q <= cfg_wdata_i[TIMEOUT_W-1:0];
          default: ;
        endcase
      end

      // Advance the timestamp pair on a pulse.
      if (in_fire && (in_i.cmd == CMD_PULSE)) begin
        older_q <= newer_q;
        newer_q <= in_i.now_us;
      end

      // Store the new speed, advance the ring and add one revolution.
      if ((state_q == ST_SPD_WAIT) && div_rsp.done) begin
        ring_vld_q[pos_q] <= 1'b1;
        pos_q  <= (pos_q == RING_IDX_W'(RING_DEPTH - 1)) ? '0
                : pos_q + RING_IDX_W'(1);
        dist_q <= dist_q + DIST_W'(circ_q);
      end

      // Drop timestamps and speeds on timeout; position and distance stay.
      if ((state_q == ST_CHECK) && timed_out) begin
        older_q    <= '0;
        newer_q    <= '0;
        ring_vld_q <= '0;
      end

      if ((state_q == ST_OUT) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      now_q      <= in_i.now_us;
      scan_idx_q <= '0;
      sum_q      <= '0;
      count_q    <= '0;
      stopped_q  <= 1'b0;
      avg_q      <= '0;
    end

    if (state_q == ST_PULSE) begin
      period_q <= newer_q - older_q;
      prod_q   <= PROD_W'(circ_q) * PROD_W'(SPEED_SCALE);
    end

    if ((state_q == ST_SPD_WAIT) && div_rsp.done) begin
      ring_q[pos_q] <= speed_sat;
    end

    if (state_q == ST_AGE) begin
      age_q <= now_q - older_q;
    end

    if ((state_q == ST_CHECK) && timed_out) begin
      stopped_q <= 1'b1;
    end

    // Accumulate one ring entry per cycle.
    if (state_q == ST_SCAN) begin
      scan_idx_q <= scan_last ? '0 : scan_idx_q + RING_IDX_W'(1);
      if (scan_take) begin
        sum_q   <= sum_q + SUM_W'(scan_entry);
        count_q <= count_q + CNT_W'(1);
      end
    end

    if ((state_q == ST_AVG_WAIT) && div_rsp.done) begin
      avg_q <= div_rsp.quotient[SPEED_W-1:0];
    end

    // Hold the result until taken.
    if ((state_q == ST_OUT) && out_free) begin
      out_avg_q     <= avg_q;
      out_dist_q    <= dist_q;
      out_stopped_q <= stopped_q;
      out_cnt_q     <= count_sat;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.avg_speed_mm_s = out_avg_q;
  assign out_o.distance_mm    = out_dist_q;
  assign out_o.stopped        = out_stopped_q;
  assign out_o.sample_count   = out_cnt_q;

  // A taken request keeps the block busy on the next cycle.
  `WST_ASSERT(a_busy_after_req, clk_i, rst_ni, in_fire |=> !in_i.ready,
              "request accepted but block ready again next cycle")

  // A result that reports a stop averages nothing.
  `WST_ASSERT(a_stop_empty, clk_i, rst_ni,
              (out_vld_q && out_stopped_q) |-> (out_avg_q == '0 && out_cnt_q == '0),
              "stopped result carries speed samples")

  // Divider completions only arrive while the sequencer waits for one.
  `WST_ASSERT(a_div_done_wait, clk_i, rst_ni,
              div_rsp.done |-> (state_q == ST_SPD_WAIT || state_q == ST_AVG_WAIT),
              "divider finished outside a wait state")

  // Ring position stays inside the ring.
  `WST_ASSERT_ALWAYS(a_pos_range, clk_i,
                     32'(pos_q) < RING_DEPTH,
                     "ring position beyond ring depth")

endmodule

// ----- rtl/core/wst_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wst_div import wst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W-1:0] den_q;

  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    trial = {rem_q, quo_q[DIV_NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    fits  = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= req_i.divisor;
      quo_q <= req_i.dividend;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
